>>> hdl/ppg_pkg.sv
// Shared types and fixed constants of the plasma pixel generator.
`default_nettype none

package ppg_pkg;

  // Field widths fixed by the interface
  localparam int PIX_W   = 10;
  localparam int TIME_W  = 16;
  localparam int FADE_W  = 10;
  localparam int VAL_W   = 8;

  // Request kinds carried by req_type
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FRAME = 1'b1
  } req_e;

  // Reset value of the fade goal, in thousandths
  localparam logic [FADE_W-1:0] FADE_GOAL_RESET = 10'd1000;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Q30 constants for the sine table build
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // Phase multipliers produce a Q16 table index
  localparam int PHASE_FRAC = 16;

  // Intensity sum: bias of four half-scale offsets
  localparam int PART_W = 10;
  localparam int SUM_W  = 12;
  localparam logic signed [SUM_W-1:0] COLOR_BIAS = 12'sd512;
  localparam int VAL_MAX = 255;

  // floor(p / 1000) == (p * FADE_RECIP) >> FADE_SHIFT for every p below 2^18
  localparam int PROD_W     = VAL_W + FADE_W;
  localparam longint unsigned FADE_RECIP = 64'd268436;
  localparam int FADE_SHIFT = 28;
  localparam int RECIP_W    = $clog2(FADE_RECIP + 1);
  localparam int SCALE_W    = PROD_W + RECIP_W;

  // Queue fill status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> hdl/ppg_queue.sv
// Small flop-based FIFO between the front and the back.
`default_nettype none

module ppg_queue #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output ppg_pkg::q_status_t status_o
);
  import ppg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

>>> hdl/ppg_front.sv
// Front end: input handshake, request decode, fade stepping and config register.
`default_nettype none

module ppg_front #(
  parameter int X_W = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [ppg_pkg::PIX_W-1:0]   pix_x_i,
  input  logic [ppg_pkg::PIX_W-1:0]   pix_y_i,
  input  logic [ppg_pkg::TIME_W-1:0]  time_count_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ppg_pkg::FADE_W-1:0]  cfg_data_i,
  input  ppg_pkg::q_status_t          q_status_i,
  output logic                        q_push_o,
  output logic [2*X_W+ppg_pkg::TIME_W+ppg_pkg::FADE_W-1:0] q_data_o
);
  import ppg_pkg::*;

  logic              in_xfer;
  logic [FADE_W-1:0] fade_goal_q, fade_goal_d;
  logic [FADE_W-1:0] fade_level_q, fade_level_d;

  assign in_stall_o  = q_status_i.full;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && !q_status_i.full;

  // pixel requests go to the back with the fade level current at transfer
  assign q_push_o = in_xfer && (req_type_i == REQ_PIXEL);
  assign q_data_o = {pix_x_i[X_W-1:0], pix_y_i[X_W-1:0], time_count_i, fade_level_q};

  // fade goal register
  always_comb begin
    fade_goal_d = fade_goal_q;
    if (cfg_valid_i && cfg_ready_o) begin
      fade_goal_d = cfg_data_i;
    end
  end

  // frame advance steps the level one count toward the goal
  always_comb begin
    fade_level_d = fade_level_q;
    if (in_xfer && (req_type_i == REQ_FRAME)) begin
      if (fade_level_q < fade_goal_q) begin
        fade_level_d = fade_level_q + 1'b1;
      end else if (fade_level_q > fade_goal_q) begin
        fade_level_d = fade_level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_goal_q  <= FADE_GOAL_RESET;
      fade_level_q <= '0;
    end else begin
      fade_goal_q  <= fade_goal_d;
      fade_level_q <= fade_level_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ppg_isqrt.sv
// Pipelined floor square root, one root bit per stage, with a sideband.
`default_nettype none

module ppg_isqrt #(
  parameter int IN_W   = 21,
  parameter int SIDE_W = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic [IN_W-1:0]          rad_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [(IN_W+1)/2-1:0]    root_o,
  output logic [SIDE_W-1:0]        side_o
);
  import ppg_pkg::*;

  localparam int ROOT_W = (IN_W + 1) / 2;
  localparam int RW     = 2 * ROOT_W + 1;

  logic [ROOT_W-1:0] vld_q;
  logic [IN_W-1:0]   rem_q  [ROOT_W];
  logic [RW-1:0]     root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam logic [RW-1:0] STEP_BIT = RW'(1) << (2 * (ROOT_W - 1 - s));

    logic              vld_in;
    logic [IN_W-1:0]   rem_in, rem_d;
    logic [RW-1:0]     root_in, root_d, trial;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // one digit of the restoring square root
    always_comb begin
      trial = root_in + STEP_BIT;
      if (RW'(rem_in) >= trial) begin
        rem_d  = rem_in - IN_W'(trial);
        root_d = (root_in >> 1) + STEP_BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1][ROOT_W-1:0];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

>>> hdl/ppg_back.sv
// Back end: sine-term pipeline, clamp, fade scaling and output register.
`default_nettype none

module ppg_back #(
  parameter int X_W              = 10,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppg_pkg::q_status_t          q_status_i,
  input  logic [2*X_W+ppg_pkg::TIME_W+ppg_pkg::FADE_W-1:0] q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ppg_pkg::VAL_W-1:0]   pixel_value_o
);
  import ppg_pkg::*;

  localparam int QW      = 2 * X_W + TIME_W + FADE_W;
  localparam int LOG_D   = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int QTAB_N  = QUARTER + 1;
  localparam int QIDX_W  = LOG_D - 1;

  // argument widths
  localparam int ARG_A_W = ((X_W > TIME_W) ? X_W : TIME_W) + 1;
  localparam int ARG_C_W = ARG_A_W + 1;
  localparam int SQ_W    = 2 * X_W + 1;
  localparam int ROOT_W  = (SQ_W + 1) / 2;
  localparam int SIDE_W  = PART_W + FADE_W;

  // phase multipliers round(2^16 * D / (2 pi div)) for div 16 and 8
  localparam longint unsigned K_DEN16 = 2 * PI_Q30 * 16;
  localparam longint unsigned K_DEN8  = 2 * PI_Q30 * 8;
  localparam longint unsigned K16 =
    ((64'(SINE_TABLE_DEPTH) << 46) + K_DEN16 / 2) / K_DEN16;
  localparam longint unsigned K8 =
    ((64'(SINE_TABLE_DEPTH) << 46) + K_DEN8 / 2) / K_DEN8;
  localparam int K16_W = $clog2(K16 + 1);
  localparam int K8_W  = $clog2(K8 + 1);
  localparam int MA_W  = ARG_A_W + K16_W;
  localparam int MC_W  = ARG_C_W + K16_W;
  localparam int MD_W  = ROOT_W + K8_W;

  localparam longint unsigned QS_DEN = 64'(2 * SINE_TABLE_DEPTH);

  typedef logic [7:0] qtab_t [QTAB_N];

  // quarter-wave table: round(128 * sin(2 pi j / D)), Q30 Taylor series
  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint unsigned m, xq, x2, term, pos, neg, s;
    int j;
    for (j = 0; j < QTAB_N; j++) begin
      m    = 64'(4 * j);
      xq   = (m * PI_Q30 + 64'(SINE_TABLE_DEPTH)) / QS_DEN;
      x2   = (xq * xq) >> 30;
      term = xq;
      pos  = xq;
      neg  = 0;
      term = ((term * x2) >> 30) / 6;   neg += term;
      term = ((term * x2) >> 30) / 20;  pos += term;
      term = ((term * x2) >> 30) / 42;  neg += term;
      term = ((term * x2) >> 30) / 72;  pos += term;
      term = ((term * x2) >> 30) / 110; neg += term;
      term = ((term * x2) >> 30) / 156; pos += term;
      term = ((term * x2) >> 30) / 210; neg += term;
      term = ((term * x2) >> 30) / 272; pos += term;
      term = ((term * x2) >> 30) / 342; neg += term;
      s = (pos > neg) ? pos - neg : 64'd0;
      tab[j] = 8'((s * 128 + (ONE_Q30 >> 1)) >> 30);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // full-wave lookup by quadrant mirroring
  function automatic logic signed [8:0] sine_lookup(input logic [LOG_D-1:0] idx);
    logic [QIDX_W-1:0] low;
    logic [QIDX_W-1:0] mi;
    logic signed [8:0] mag;
    low = QIDX_W'(idx[LOG_D-3:0]);
    mi  = idx[LOG_D-2] ? QIDX_W'(QUARTER) - low : low;
    mag = $signed({1'b0, QTAB[mi]});
    return idx[LOG_D-1] ? -mag : mag;
  endfunction

  // pipeline advances unless a finished result is held by the stall
  logic adv;
  assign adv     = !out_valid_o || !out_stall_i;
  assign q_pop_o = adv && !q_status_i.empty;

  // queue entry fields
  logic [X_W-1:0]    e_x, e_y;
  logic [TIME_W-1:0] e_t;
  logic [FADE_W-1:0] e_fade;
  assign {e_x, e_y, e_t, e_fade} = q_data_i;

  // stage 1: arguments and squares
  logic                s1_valid_q;
  logic [ARG_A_W-1:0]  s1_arg_a_q, s1_arg_b_q;
  logic [ARG_C_W-1:0]  s1_arg_c_q;
  logic [2*X_W-1:0]    s1_xsq_q, s1_ysq_q;
  logic [FADE_W-1:0]   s1_fade_q;

  // stage 2: table indexes and radicand
  logic                s2_valid_q;
  logic [LOG_D-1:0]    s2_idx_a_q, s2_idx_b_q, s2_idx_c_q;
  logic [SQ_W-1:0]     s2_sq_q;
  logic [FADE_W-1:0]   s2_fade_q;
  logic [MA_W-1:0]     prod_a, prod_b;
  logic [MC_W-1:0]     prod_c;

  // stage 3: partial sum of three terms
  logic                    s3_valid_q;
  logic signed [PART_W-1:0] s3_part_q, part_d;
  logic [SQ_W-1:0]         s3_sq_q;
  logic [FADE_W-1:0]       s3_fade_q;

  // square root pipeline
  logic                    r_valid;
  logic [ROOT_W-1:0]       r_root;
  logic [SIDE_W-1:0]       r_side;

  // stage 4: radial index
  logic                     s4_valid_q;
  logic [LOG_D-1:0]         s4_idx_d_q;
  logic signed [PART_W-1:0] s4_part_q;
  logic [FADE_W-1:0]        s4_fade_q;
  logic [MD_W-1:0]          prod_d;

  // stage 5: clamped color
  logic                     s5_valid_q;
  logic [VAL_W-1:0]         s5_color_q, color_d;
  logic [FADE_W-1:0]        s5_fade_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic [SUM_W-3:0]         quot;

  // stage 6 and 7: fade product and reciprocal scaling
  logic                     s6_valid_q;
  logic [PROD_W-1:0]        s6_prod_q;
  logic                     s7_valid_q;
  logic [SCALE_W-1:0]       s7_scale_q;
  logic [SCALE_W-FADE_SHIFT-1:0] scaled;
  logic [VAL_W-1:0]         pixel_d;

  assign prod_a = MA_W'(s1_arg_a_q) * MA_W'(K16);
  assign prod_b = MA_W'(s1_arg_b_q) * MA_W'(K8);
  assign prod_c = MC_W'(s1_arg_c_q) * MC_W'(K16);

  assign part_d = PART_W'(sine_lookup(s2_idx_a_q)) + PART_W'(sine_lookup(s2_idx_b_q))
                + PART_W'(sine_lookup(s2_idx_c_q));

  assign prod_d = MD_W'(r_root) * MD_W'(K8);

  // final sum, divide by four, clamp
  always_comb begin
    sum_d = COLOR_BIAS + SUM_W'(s4_part_q) + SUM_W'(sine_lookup(s4_idx_d_q));
    quot  = sum_d[SUM_W-1:2];
    if (sum_d < 0) begin
      color_d = '0;
    end else if (quot > (SUM_W-2)'(VAL_MAX)) begin
      color_d = VAL_W'(VAL_MAX);
    end else begin
      color_d = quot[VAL_W-1:0];
    end
  end

  // divide by 1000 and saturate
  assign scaled  = s7_scale_q[SCALE_W-1:FADE_SHIFT];
  assign pixel_d = (scaled > (SCALE_W-FADE_SHIFT)'(VAL_MAX)) ? VAL_W'(VAL_MAX)
                                                           : scaled[VAL_W-1:0];

  ppg_isqrt #(
    .IN_W   (SQ_W),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s3_valid_q),
    .rad_i   (s3_sq_q),
    .side_i  ({s3_part_q, s3_fade_q}),
    .valid_o (r_valid),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_status_i.empty;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= r_valid;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= s6_valid_q;
      out_valid_o <= s7_valid_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_arg_a_q    <= ARG_A_W'(e_x) + ARG_A_W'(e_t);
      s1_arg_b_q    <= ARG_A_W'(e_y) + ARG_A_W'(e_t);
      s1_arg_c_q    <= ARG_C_W'(e_x) + ARG_C_W'(e_y) + (ARG_C_W'(e_t) << 1);
      s1_xsq_q      <= (2*X_W)'(e_x) * (2*X_W)'(e_x);
      s1_ysq_q      <= (2*X_W)'(e_y) * (2*X_W)'(e_y);
      s1_fade_q     <= e_fade;

      s2_idx_a_q    <= prod_a[PHASE_FRAC +: LOG_D];
      s2_idx_b_q    <= prod_b[PHASE_FRAC +: LOG_D];
      s2_idx_c_q    <= prod_c[PHASE_FRAC +: LOG_D];
      s2_sq_q       <= SQ_W'(s1_xsq_q) + SQ_W'(s1_ysq_q);
      s2_fade_q     <= s1_fade_q;

      s3_part_q     <= part_d;
      s3_sq_q       <= s2_sq_q;
      s3_fade_q     <= s2_fade_q;

      s4_idx_d_q    <= prod_d[PHASE_FRAC +: LOG_D];
      s4_part_q     <= $signed(r_side[SIDE_W-1:FADE_W]);
      s4_fade_q     <= r_side[FADE_W-1:0];

      s5_color_q    <= color_d;
      s5_fade_q     <= s4_fade_q;

      s6_prod_q     <= PROD_W'(s5_color_q) * PROD_W'(s5_fade_q);

      s7_scale_q    <= SCALE_W'(s6_prod_q) * SCALE_W'(FADE_RECIP);

      pixel_value_o <= pixel_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/plasma_pixel_generator_core.sv
// Top level of the sine plasma pixel generator.
`default_nettype none

// Takes one request per clock over a valid/stall channel while in_stall_o is
// low. A pixel request returns one faded intensity on the output channel, in
// request order; a frame request steps the fade level one count toward
// fade_goal and returns nothing. Sustained rate is one request per clock while
// out_stall_i holds no result. A four-entry queue sits between the request
// decoder and the pixel pipeline; in_stall_o rises only after the queue fills
// while a result is held by out_stall_i. Each pixel uses the fade level in
// effect when it was transferred. fade_goal is written through the cfg port,
// always ready; the user must write it only while no request is in flight, as
// the block does not enforce this.

module plasma_pixel_generator_core #(
  parameter int COORD_BITS       = 10,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [ppg_pkg::PIX_W-1:0]   pix_x_i,
  input  logic [ppg_pkg::PIX_W-1:0]   pix_y_i,
  input  logic [ppg_pkg::TIME_W-1:0]  time_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ppg_pkg::VAL_W-1:0]   pixel_value_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ppg_pkg::FADE_W-1:0]  cfg_data_i
);
  import ppg_pkg::*;

  // COORD_BITS is capped at the port width; coordinate bits above it are ignored
  localparam int X_W = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam int QW  = 2 * X_W + TIME_W + FADE_W;

  q_status_t     q_status;
  logic          q_push, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  ppg_front #(
    .X_W (X_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .pix_x_i      (pix_x_i),
    .pix_y_i      (pix_y_i),
    .time_count_i (time_count_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .q_status_i   (q_status),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  ppg_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .status_o    (q_status)
  );

  ppg_back #(
    .X_W              (X_W),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o)
  );

endmodule

`default_nettype wire

>>> hdl/ppg_checker.sv
// Port-level checks for the plasma pixel generator, bound to the top level.
`default_nettype none

module ppg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [ppg_pkg::VAL_W-1:0] pixel_value_o
);
  import ppg_pkg::*;

  // nothing pending and nothing offered while in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("output valid or input stall seen during reset");

  // the queue can only fill while a result is held on the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without a held result");

  // a full queue stays full while the output is still held
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_valid_o && out_stall_i |=> in_stall_o)
    else $error("input stall dropped while the pipeline was frozen");

  // a stalled result keeps its valid and value
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o))
    else $error("stalled result changed before transfer");

endmodule

bind plasma_pixel_generator_core ppg_checker u_ppg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_value_o (pixel_value_o)
);

`default_nettype wire
